/* rtl/calsec_pkg.sv */
`timescale 1ns / 1ps

package calsec_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int ACC_W       = 32;
    localparam int YEARS_W     = 7;

    localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;

    // One input transaction, unpacked.
    typedef struct packed {
        logic [6:0] year_two_digit;
        logic [3:0] month_number;
        logic [4:0] day_of_month;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
        logic [4:0] zone_hours;
    } item_t;

    // Operation applied to the accumulator.
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_CLEAR = 4'd1,
        OP_YEAR  = 4'd2,
        OP_MONTH = 4'd3,
        OP_DAY   = 4'd4,
        OP_MUL24 = 4'd5,
        OP_HOUR  = 4'd6,
        OP_ZONE  = 4'd7,
        OP_MUL60 = 4'd8,
        OP_MIN   = 4'd9,
        OP_SEC   = 4'd10
    } op_t;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_YEAR   = 12'b0000_0000_0010,
        ST_MONTH  = 12'b0000_0000_0100,
        ST_DAY    = 12'b0000_0000_1000,
        ST_MUL24  = 12'b0000_0001_0000,
        ST_HOUR   = 12'b0000_0010_0000,
        ST_ZONE   = 12'b0000_0100_0000,
        ST_MUL60M = 12'b0000_1000_0000,
        ST_MIN    = 12'b0001_0000_0000,
        ST_MUL60S = 12'b0010_0000_0000,
        ST_SEC    = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    // Sequencer to datapath control.
    typedef struct packed {
        op_t  op;
        logic year_leap;
    } ctrl_t;

    // Whole years between 1970 and the full year that the two-digit year stands for.
    function automatic logic [YEARS_W-1:0] years_since_epoch(input logic [6:0] yy);
        logic [YEARS_W-1:0] n;
        if (yy < 7'd70)
        begin
            n = yy + 7'd30;
        end
        else
        begin
            n = yy - 7'd70;
        end
        return n;
    endfunction

    // The full years reachable here run from 1970 to 2069. The only century year among
    // them is 2000, which is divisible by 400, so a year is leap exactly when it is a
    // multiple of four, that is when its distance from 1970 is two modulo four.
    function automatic logic is_leap_offset(input logic [YEARS_W-1:0] n);
        return (n[1:0] == 2'd2);
    endfunction

    // Days of the whole months before the given month. Month zero counts none, and
    // months past December count the full year.
    function automatic logic [8:0] month_days(input logic [3:0] mon, input logic leap);
        logic [8:0] d;
        case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59  + {8'd0, leap};
            4'd4:    d = 9'd90  + {8'd0, leap};
            4'd5:    d = 9'd120 + {8'd0, leap};
            4'd6:    d = 9'd151 + {8'd0, leap};
            4'd7:    d = 9'd181 + {8'd0, leap};
            4'd8:    d = 9'd212 + {8'd0, leap};
            4'd9:    d = 9'd243 + {8'd0, leap};
            4'd10:   d = 9'd273 + {8'd0, leap};
            4'd11:   d = 9'd304 + {8'd0, leap};
            4'd12:   d = 9'd334 + {8'd0, leap};
            default: d = DAYS_COMMON_YEAR + {8'd0, leap};
        endcase
        return d;
    endfunction

endpackage

/* rtl/calsec_ctrl.sv */
`timescale 1ns / 1ps

module calsec_ctrl
    import calsec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        out_free,
    input  logic [6:0]  year_two_digit,
    output ctrl_t       ctrl,
    output logic        idle,
    output logic        load_out
);

    state_t             state_reg;
    state_t             state_next;
    logic [YEARS_W-1:0] k_reg;
    logic [YEARS_W-1:0] k_next;
    logic [YEARS_W-1:0] nyears;
    op_t                op;

    assign nyears = years_since_epoch(year_two_digit);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        op         = OP_NONE;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op         = OP_CLEAR;
                    k_next     = '0;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (k_reg != nyears)
                begin
                    op     = OP_YEAR;
                    k_next = k_reg + 7'd1;
                end
                else
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                op         = OP_MONTH;
                state_next = ST_DAY;
            end
            ST_DAY:
            begin
                op         = OP_DAY;
                state_next = ST_MUL24;
            end
            ST_MUL24:
            begin
                op         = OP_MUL24;
                state_next = ST_HOUR;
            end
            ST_HOUR:
            begin
                op         = OP_HOUR;
                state_next = ST_ZONE;
            end
            ST_ZONE:
            begin
                op         = OP_ZONE;
                state_next = ST_MUL60M;
            end
            ST_MUL60M:
            begin
                op         = OP_MUL60;
                state_next = ST_MIN;
            end
            ST_MIN:
            begin
                op         = OP_MIN;
                state_next = ST_MUL60S;
            end
            ST_MUL60S:
            begin
                op         = OP_MUL60;
                state_next = ST_SEC;
            end
            ST_SEC:
            begin
                op         = OP_SEC;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    assign ctrl.op        = op;
    assign ctrl.year_leap = is_leap_offset(k_reg);
    assign idle           = (state_reg == ST_IDLE);

    a_start_enters_year: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == ST_YEAR))
        else $error("sequencer did not enter the year loop after a start");

    a_year_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YEAR) |-> (k_reg <= nyears))
        else $error("year counter ran past the number of whole years");

    a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after loading the result");

endmodule

/* rtl/calsec_dp.sv */
`timescale 1ns / 1ps

module calsec_dp
    import calsec_pkg::*;
(
    input  logic             clk,
    input  ctrl_t            ctrl,
    input  item_t            item,
    output logic [ACC_W-1:0] acc
);

    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [ACC_W-1:0]   opa;
    logic [ACC_W-1:0]   opb;
    logic               cin;
    logic [ACC_W-1:0]   sum;
    logic               target_leap;

    assign target_leap = is_leap_offset(years_since_epoch(item.year_two_digit));

    // The one shared adder. Subtraction uses the inverted operand and a carry in.
    assign sum = opa + opb + {{(ACC_W-1){1'b0}}, cin};

    always_comb
    begin
        opa      = acc_reg;
        opb      = '0;
        cin      = 1'b0;
        acc_next = acc_reg;
        case (ctrl.op)
            OP_NONE:
            begin
                acc_next = acc_reg;
            end
            OP_CLEAR:
            begin
                // Starting at minus one folds in the day-of-month offset.
                acc_next = '1;
            end
            OP_YEAR:
            begin
                opb      = {23'd0, DAYS_COMMON_YEAR + {8'd0, ctrl.year_leap}};
                acc_next = sum;
            end
            OP_MONTH:
            begin
                opb      = {23'd0, month_days(item.month_number, target_leap)};
                acc_next = sum;
            end
            OP_DAY:
            begin
                opb      = {27'd0, item.day_of_month};
                acc_next = sum;
            end
            OP_MUL24:
            begin
                opa      = {acc_reg[ACC_W-5:0], 4'd0};
                opb      = {acc_reg[ACC_W-4:0], 3'd0};
                acc_next = sum;
            end
            OP_HOUR:
            begin
                opb      = {27'd0, item.hour_of_day};
                acc_next = sum;
            end
            OP_ZONE:
            begin
                opb      = ~{{27{item.zone_hours[4]}}, item.zone_hours};
                cin      = 1'b1;
                acc_next = sum;
            end
            OP_MUL60:
            begin
                opa      = {acc_reg[ACC_W-7:0], 6'd0};
                opb      = ~{acc_reg[ACC_W-3:0], 2'd0};
                cin      = 1'b1;
                acc_next = sum;
            end
            OP_MIN:
            begin
                opb      = {26'd0, item.minute_of_hour};
                acc_next = sum;
            end
            OP_SEC:
            begin
                opb      = {26'd0, item.second_of_minute};
                acc_next = sum;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

/* rtl/calendar_to_epoch_seconds.sv */
`timescale 1ns / 1ps

// Converts one local calendar date and time into seconds since 1970-01-01 UTC.
// Input channel s_*: one transaction carries year, month, day, hour, minute, second
// and a whole-hour zone offset. Output channel m_*: one transaction per input with
// the epoch seconds, wrapping modulo 2^32.
// A single 32-bit adder does all the arithmetic under a small sequencer. The year
// loop adds 365 or 366 once per whole year since 1970 (n = 0 to 99 years). Then
// the month, day, hour, minute and second terms are added and the zone term is
// subtracted, and the scaling by 24 and twice by 60 is done as shift-and-add and
// shift-and-subtract passes through the same adder. A new input is taken only
// after the previous result has been loaded into the output register.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register. If the receiver stalls, the sequencer
// holds in its final step until the register is free, so a result is never lost.
// Reset empties the output register and returns the sequencer to idle. No result
// is pending after reset.
module calendar_to_epoch_seconds
    import calsec_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [6:0] year_two_digit, [10:7] month_number, [15:11] day_of_month,
    // [20:16] hour_of_day, [26:21] minute_of_hour, [32:27] second_of_minute,
    // [37:33] zone_hours, [39:38] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] epoch_seconds
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    item_t                   item_reg;
    item_t                   item_in;
    ctrl_t                   ctrl;
    logic                    idle;
    logic                    load_out;
    logic                    accept;
    logic                    out_free;
    logic [ACC_W-1:0]        acc;
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;

    assign item_in.year_two_digit   = s_tdata[6:0];
    assign item_in.month_number     = s_tdata[10:7];
    assign item_in.day_of_month     = s_tdata[15:11];
    assign item_in.hour_of_day      = s_tdata[20:16];
    assign item_in.minute_of_hour   = s_tdata[26:21];
    assign item_in.second_of_minute = s_tdata[32:27];
    assign item_in.zone_hours       = s_tdata[37:33];

    assign s_tready = idle;
    assign accept   = s_tvalid && idle;
    assign out_free = !m_tvalid_reg || m_tready;

    // The input fields are held for the whole conversion.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

    calsec_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (accept),
        .out_free       (out_free),
        .year_two_digit (item_reg.year_two_digit),
        .ctrl           (ctrl),
        .idle           (idle),
        .load_out       (load_out)
    );

    calsec_dp u_dp (
        .clk  (clk),
        .ctrl (ctrl),
        .item (item_reg),
        .acc  (acc)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata_reg <= acc;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("block took a second transaction while converting");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (m_tvalid && (m_tdata == $past(acc))))
        else $error("finished result was not presented on the output");

endmodule

/* verif/calendar_to_epoch_seconds_test.sv */
`timescale 1ns / 1ps

// Testbench for the calendar to epoch seconds converter.
//
// A queue of calendar items is built at time zero. The directed part comes
// first, then the random part. A clocked driver offers the items on the slave
// stream in bursts with random gaps between them. A clocked monitor takes the
// results from the master stream while the receiver stalls on its own pattern.
// Every accepted input transaction is run through a local predictor at the
// moment it is accepted. The predicted epoch value waits in a queue until the
// matching output transaction arrives, and the two are compared there.
module calendar_to_epoch_seconds_test;
    import calsec_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 150;
    localparam int LONG_HOLD    = 1200;  // receiver hold-off, in cycles

    // Stall patterns of the receiver.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    // One queued item. When drain_first is set, the driver waits until every
    // expected result has arrived before it offers the item.
    typedef struct packed {
        logic  drain_first;
        item_t fields;
    } pending_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [6:0] year_two_digit, [10:7] month_number, [15:11] day_of_month,
    // [20:16] hour_of_day, [26:21] minute_of_hour, [32:27] second_of_minute,
    // [37:33] zone_hours, [39:38] zero
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [31:0] epoch_seconds
    logic [OUT_TDATA_W-1:0] m_tdata;

    pending_item_t          pending_q[$];
    logic [31:0]            epoch_expect_q[$];
    item_t                  offered_item;

    int                     accepted_count = 0;
    int                     checked_count = 0;
    int                     error_count = 0;
    int                     odd_field_count = 0;
    int                     hold_count = 0;
    int                     cycle_count = 0;

    calendar_to_epoch_seconds i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Gregorian rule: every fourth year, except century years not divisible
    // by 400.
    function automatic logic is_gregorian_leap(input int unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    // Days before the first of a month in a common year, indexed by the
    // number of whole months already gone.
    function automatic logic [31:0] common_days_before(input int unsigned months_done);
        logic [31:0] d;
        case (months_done)
            0:       d = 32'd0;
            1:       d = 32'd31;
            2:       d = 32'd59;
            3:       d = 32'd90;
            4:       d = 32'd120;
            5:       d = 32'd151;
            6:       d = 32'd181;
            7:       d = 32'd212;
            8:       d = 32'd243;
            9:       d = 32'd273;
            10:      d = 32'd304;
            11:      d = 32'd334;
            default: d = 32'd365;
        endcase
        return d;
    endfunction

    // Epoch seconds for one local calendar item. Every term wraps modulo
    // 2^32, which covers a day of zero and zone offsets that push the result
    // below the epoch or past the top of the range.
    function automatic logic [31:0] epoch_of_local_time(input item_t it);
        int unsigned        full_year;
        int unsigned        yr;
        int unsigned        months_done;
        logic [31:0]        day_count;
        logic [31:0]        secs;
        logic signed [31:0] zone_ext;
        full_year = it.year_two_digit + ((it.year_two_digit < 7'd70) ? 2000 : 1900);
        day_count = 32'd0;
        for (yr = 1970; yr < full_year; yr++)
        begin
            day_count += is_gregorian_leap(yr) ? 32'd366 : 32'd365;
        end
        // A month of zero counts nothing; months past December count the
        // whole current year.
        months_done = (it.month_number == 4'd0) ? 0 : it.month_number - 1;
        if (months_done > 12)
        begin
            months_done = 12;
        end
        day_count += common_days_before(months_done);
        if (months_done >= 2 && is_gregorian_leap(full_year))
        begin
            day_count += 32'd1;
        end
        secs = day_count * 32'd86400;
        secs += ({27'd0, it.day_of_month} - 32'd1) * 32'd86400;
        secs += {27'd0, it.hour_of_day} * 32'd3600;
        secs += {26'd0, it.minute_of_hour} * 32'd60;
        secs += {26'd0, it.second_of_minute};
        zone_ext = $signed(it.zone_hours);
        secs -= zone_ext * 32'sd3600;
        return secs;
    endfunction

    // Lowest field in the lowest bits, two zero bits on top.
    function automatic logic [IN_TDATA_W-1:0] tdata_of(input item_t it);
        return {2'b00, it.zone_hours, it.second_of_minute, it.minute_of_hour,
                it.hour_of_day, it.day_of_month, it.month_number, it.year_two_digit};
    endfunction

    task automatic queue_item(input logic [6:0] yy, input logic [3:0] mon,
                              input logic [4:0] day, input logic [4:0] hr,
                              input logic [5:0] mn, input logic [5:0] sc,
                              input logic [4:0] zone, input logic drain_first);
        pending_item_t entry;
        entry.drain_first             = drain_first;
        entry.fields.year_two_digit   = yy;
        entry.fields.month_number     = mon;
        entry.fields.day_of_month     = day;
        entry.fields.hour_of_day      = hr;
        entry.fields.minute_of_hour   = mn;
        entry.fields.second_of_minute = sc;
        entry.fields.zone_hours       = zone;
        pending_q.push_back(entry);
        if (yy > 7'd99 || mon == 4'd0 || mon > 4'd12 || day == 5'd0 || hr > 5'd23 ||
            mn > 6'd59 || sc > 6'd59 || ($signed(zone) < -5'sd12))
        begin
            odd_field_count++;
        end
    endtask

    // Sender. Items go out in bursts of random length; between bursts the
    // sender stays quiet for a random number of cycles, sometimes none.
    // tvalid stays high with stable data until the transaction is accepted.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic          offer_open;
        logic          next_valid;
        pending_item_t head;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            offer_open = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                epoch_expect_q.push_back(epoch_of_local_time(offered_item));
                accepted_count++;
                offer_open = 1'b0;
            end
            next_valid = offer_open;
            if (!offer_open)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain_first && epoch_expect_q.size() != 0))
                begin
                    head         = pending_q.pop_front();
                    offered_item = head.fields;
                    next_valid   = 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 130);
                    end
                end
            end
            s_tvalid <= next_valid;
            s_tdata  <= tdata_of(offered_item);
        end
    end

    // Receiver. It switches between always ready, a coin toss per cycle and
    // mostly stalled. Twice in the run it holds off for a long stretch while
    // the sender keeps offering, so the output register fills and the block
    // stops taking input.
    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_phase_left = 0;
    int       hold_left = 0;
    int       next_hold_at = 40;

    always @(posedge clk or negedge rst_n)
    begin
        logic ready_next;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (hold_count < 2 && accepted_count >= next_hold_at)
            begin
                hold_left    = LONG_HOLD;
                next_hold_at = next_hold_at + 800;
                hold_count++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                if (rx_phase_left == 0)
                begin
                    rx_mode       = rx_mode_t'($urandom_range(0, 2));
                    rx_phase_left = $urandom_range(20, 400);
                end
                rx_phase_left--;
                case (rx_mode)
                    RX_ALWAYS: ready_next = 1'b1;
                    RX_RANDOM: ready_next = ($urandom_range(0, 1) == 1);
                    default:   ready_next = ($urandom_range(0, 5) == 0);
                endcase
            end
            m_tready <= ready_next;
        end
    end

    // Checker on the master stream.
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (epoch_expect_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("[%0t] unexpected result: epoch_seconds = 0x%08h", $realtime,
                             m_tdata);
                end
            end
            else
            begin
                want = epoch_expect_q.pop_front();
                checked_count++;
                if (m_tdata !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("[%0t] epoch_seconds: expected 0x%08h, got 0x%08h",
                                 $realtime, want, m_tdata);
                    end
                end
            end
        end
    end

    // Hard stop in case the handshake hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles, %0d results outstanding", $realtime,
                     cycle_count, epoch_expect_q.size());
            $display("calendar_to_epoch_seconds: mismatch");
            $finish;
        end
    end

    initial
    begin
        int          i;
        logic [6:0]  yy;
        logic [3:0]  mon;
        logic [4:0]  day;
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [5:0]  sc;
        logic [4:0]  zone;

        // Directed items: the epoch itself, the ends of the year range, the
        // leap century 2000, the leap day, years past 99 and months outside
        // 1 to 12, day zero, saturated time fields, and zone offsets at both
        // ends of the five-bit range including a wrap below the epoch.
        queue_item(7'd70,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  5'd0,         1'b0);
        queue_item(7'd70,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  5'd1,         1'b0);
        queue_item(7'd70,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  5'b10000,     1'b0);
        queue_item(7'd69,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 5'd0,         1'b0);
        queue_item(7'd69,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 5'b10000,     1'b0);
        queue_item(7'd0,   4'd2,  5'd29, 5'd12, 6'd30, 6'd30, 5'd0,         1'b0);
        queue_item(7'd0,   4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  5'd14,        1'b0);
        queue_item(7'd72,  4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  5'b10100,     1'b0);
        queue_item(7'd71,  4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  5'b11111,     1'b0);
        queue_item(7'd99,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 5'd0,         1'b0);
        queue_item(7'd100, 4'd6,  5'd15, 5'd8,  6'd0,  6'd0,  5'd0,         1'b0);
        queue_item(7'd127, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  5'd0,         1'b0);
        queue_item(7'd24,  4'd0,  5'd10, 5'd1,  6'd2,  6'd3,  5'd0,         1'b0);
        queue_item(7'd24,  4'd12, 5'd10, 5'd1,  6'd2,  6'd3,  5'd0,         1'b0);
        queue_item(7'd24,  4'd13, 5'd10, 5'd1,  6'd2,  6'd3,  5'd0,         1'b0);
        queue_item(7'd23,  4'd15, 5'd10, 5'd1,  6'd2,  6'd3,  5'd0,         1'b0);
        queue_item(7'd50,  4'd5,  5'd0,  5'd0,  6'd0,  6'd0,  5'd0,         1'b0);
        queue_item(7'd70,  4'd1,  5'd0,  5'd0,  6'd0,  6'd0,  5'd0,         1'b0);
        queue_item(7'd33,  4'd7,  5'd31, 5'd31, 6'd63, 6'd63, 5'd15,        1'b0);
        queue_item(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 5'b11111,     1'b0);
        queue_item(7'd0,   4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  5'd0,         1'b0);
        queue_item(7'd85,  4'd9,  5'd17, 5'd6,  6'd45, 6'd12, 5'd15,        1'b0);

        // Random items. Most are well-formed dates with in-range zones; the
        // rest put arbitrary bits in every field. Every few hundred items the
        // sender waits for the output side to drain completely first.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                yy   = 7'($urandom_range(0, 99));
                mon  = 4'($urandom_range(1, 12));
                day  = 5'($urandom_range(1, 31));
                hr   = 5'($urandom_range(0, 23));
                mn   = 6'($urandom_range(0, 59));
                sc   = 6'($urandom_range(0, 59));
                zone = 5'($signed($urandom_range(0, 26)) - 12);
            end
            else
            begin
                yy   = 7'($urandom);
                mon  = 4'($urandom);
                day  = 5'($urandom);
                hr   = 5'($urandom);
                mn   = 6'($urandom);
                sc   = 6'($urandom);
                zone = 5'($urandom);
            end
            queue_item(yy, mon, day, hr, mn, sc, zone, (i % 300) == 0);
        end

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // All stimulus accepted, then every expected result in, then a quiet
        // stretch to catch any stray output transaction.
        while (pending_q.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (epoch_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d conversions, %0d of them with fields outside nominal ranges.",
                 checked_count, odd_field_count);
        $display("Output held off %0d times for %0d cycles; %0d errors.", hold_count,
                 LONG_HOLD, error_count);
        if (error_count == 0 && epoch_expect_q.size() == 0)
        begin
            $display("calendar_to_epoch_seconds: match");
        end
        else
        begin
            $display("calendar_to_epoch_seconds: mismatch");
        end
        $finish;
    end

endmodule

/* calendar_to_epoch_seconds.f */
rtl/calsec_pkg.sv
rtl/calsec_ctrl.sv
rtl/calsec_dp.sv
rtl/calendar_to_epoch_seconds.sv
verif/calendar_to_epoch_seconds_test.sv
